// ===== rtl/core/tae_pkg.sv =====
package tae_pkg;

	localparam int TAB_LEN          = 24;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int IDX_W            = 5;
	localparam int XY_W             = 20;
	localparam int Z_W              = 26;
	localparam int THETA_W          = 20;
	localparam int ANGLE_W          = 16;
	localparam int SHIFT_W          = 3;
	localparam int TAB_W            = 22;
	localparam int NUM_LANES        = 3;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd2;
	localparam logic [Z_W-1:0]     ANGLE_PI    = 26'd8388608;

	localparam logic signed [THETA_W-1:0] THETA_MAX = 20'sd524287;
	localparam logic signed [THETA_W-1:0] THETA_MIN = -20'sd524288;

	// Rate scaling: round(g * 4096 / 6000) = floor((1024 * |g| + 750) / 1500).
	localparam logic [20:0] RATE_RECIP = 21'd1431655;
	localparam logic [10:0] RATE_DIV   = 11'd1500;
	localparam logic [9:0]  RATE_BIAS  = 10'd750;

	typedef logic signed [THETA_W-1:0] theta_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [IDX_W-1:0] idx;
	} lane_ctl_t;

	function automatic logic [TAB_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
		logic [TAB_W-1:0] v;
		case (idx)
			5'd0:    v = 22'd2097152;
			5'd1:    v = 22'd1238021;
			5'd2:    v = 22'd654136;
			5'd3:    v = 22'd332050;
			5'd4:    v = 22'd166669;
			5'd5:    v = 22'd83416;
			5'd6:    v = 22'd41718;
			5'd7:    v = 22'd20860;
			5'd8:    v = 22'd10430;
			5'd9:    v = 22'd5215;
			5'd10:   v = 22'd2608;
			5'd11:   v = 22'd1304;
			5'd12:   v = 22'd652;
			5'd13:   v = 22'd326;
			5'd14:   v = 22'd163;
			5'd15:   v = 22'd81;
			5'd16:   v = 22'd41;
			5'd17:   v = 22'd20;
			5'd18:   v = 22'd10;
			5'd19:   v = 22'd5;
			5'd20:   v = 22'd3;
			5'd21:   v = 22'd1;
			5'd22:   v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

	// Sign extension from bit 10 as the sensor delivers it; bit 10 clear leaves w as is.
	function automatic logic signed [15:0] accel_value(input logic [15:0] w);
		logic [15:0] u;
		u = w[10] ? (w | 16'hF800) : w;
		return $signed(u);
	endfunction

endpackage

// ===== rtl/core/tae_if.sv =====
interface tae_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] accel_x_word;
	logic [15:0] accel_y_word;
	logic [15:0] accel_z_word;
	logic signed [15:0] gyro_x_raw;
	logic signed [15:0] gyro_y_raw;
	logic signed [15:0] gyro_z_raw;

	modport source (output valid, accel_x_word, accel_y_word, accel_z_word,
		gyro_x_raw, gyro_y_raw, gyro_z_raw, input ready);
	modport sink (input valid, accel_x_word, accel_y_word, accel_z_word,
		gyro_x_raw, gyro_y_raw, gyro_z_raw, output ready);
endinterface

interface tae_out_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic signed [15:0] roll_rate;
	logic signed [15:0] pitch_rate;
	logic signed [15:0] yaw_rate;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle,
		roll_rate, pitch_rate, yaw_rate, input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle,
		roll_rate, pitch_rate, yaw_rate, output ready);
endinterface

// ===== rtl/core/tilt_angle_estimator_unit.sv =====
// Tilt angle estimator.
// One item on the sample channel carries three raw accelerometer words and
// three gyro words; one item on the result channel carries three smoothed
// tilt angles (Q2.14, units of pi/2) and three gyro rates (Q4.12).
// The sample channel is ready only while the block is idle. An accepted item
// runs through three CORDIC lanes in parallel, one lane per angle, each
// doing one vectoring step per cycle; then the angles are captured, the
// averages updated and the result loaded. One item is in flight at a time:
// the block takes the next only after the result of the last is loaded.
// The result register parts the two sides: the next item is accepted while
// a finished result still waits. When the receiver stalls, a finished item
// waits before its result is loaded, with the averages already updated.
// Reset clears the averages to zero, the smoothing shift to 2 and empties
// the result register. The user must write the smoothing shift through
// cfg_wen and cfg_wdata while the block is idle; the block itself does not
// enforce it.
module tilt_angle_estimator_unit #(
	parameter int CORDIC_STEPS = tae_pkg::CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tae_in_if.sink                      sample,
	tae_out_if.source                   result,
	input  logic                        cfg_wen,
	input  logic [tae_pkg::SHIFT_W-1:0] cfg_wdata
);
	import tae_pkg::*;

	localparam int RUN_STEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RUN_STEPS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_THETA,
		ST_UPDATE,
		ST_LOAD
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [SHIFT_W-1:0] shift_q;
	logic               out_valid_q;
	lane_ctl_t          ctl;
	logic               accept, load_out;

	logic signed [15:0] ax, ay, az;
	logic signed [16:0] ly [NUM_LANES];
	logic signed [16:0] lx [NUM_LANES];
	theta_t             theta [NUM_LANES];
	angle_t             angle [NUM_LANES];
	logic signed [15:0] rate_x, rate_y, rate_z;

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign load_out     = (state_q == ST_LOAD) && (!out_valid_q || result.ready);

	assign ctl.load = accept;
	assign ctl.step = (state_q == ST_RUN);
	assign ctl.idx  = idx_q;

	// Operands: roll = atan2(ax, az), pitch = atan2(-ay, az), yaw = atan2(ay, ax).
	assign ax = accel_value(sample.accel_x_word);
	assign ay = accel_value(sample.accel_y_word);
	assign az = accel_value(sample.accel_z_word);

	assign ly[0] = 17'(ax);
	assign lx[0] = 17'(az);
	assign ly[1] = -17'(ay);
	assign lx[1] = 17'(az);
	assign ly[2] = 17'(ay);
	assign lx[2] = 17'(ax);

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		tae_cordic_lane u_lane (
			.clk   (clk),
			.ctl   (ctl),
			.y_in  (ly[i]),
			.x_in  (lx[i]),
			.theta (theta[i])
		);
	end

	tae_smooth u_smooth (
		.clk     (clk),
		.arst_n  (arst_n),
		.capture (state_q == ST_THETA),
		.update  (state_q == ST_UPDATE),
		.shift   (shift_q),
		.theta   (theta),
		.angle   (angle)
	);

	// The rate units register through stages s1, s2 and s3 and settle long before the lanes finish.
	tae_rate u_rate_x (.clk(clk), .load(accept), .raw(sample.gyro_x_raw), .rate(rate_x));
	tae_rate u_rate_y (.clk(clk), .load(accept), .raw(sample.gyro_y_raw), .rate(rate_y));
	tae_rate u_rate_z (.clk(clk), .load(accept), .raw(sample.gyro_z_raw), .rate(rate_z));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= SHIFT_RESET;
		end else if (cfg_wen) begin
			shift_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result takes the register; otherwise a taken one leaves it.
			if (load_out)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == LAST_IDX)
						state_q <= ST_THETA;
				end
				ST_THETA: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result.roll_angle  <= angle[0];
			result.pitch_angle <= angle[1];
			result.yaw_angle   <= angle[2];
			result.roll_rate   <= rate_x;
			result.pitch_rate  <= rate_y;
			result.yaw_rate    <= rate_z;
		end
	end

	assign result.valid = out_valid_q;

	// The step index never runs past the last table entry in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (idx_q <= LAST_IDX))
		else $error("step index beyond the last step");

	// An accepted item always enters the lane iterations next.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (idx_q == '0))
		else $error("accepted item did not start the lanes");

	// A waiting result is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !load_out)
		else $error("pending result overwritten");

	// The averages change only once per item, after the lanes finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> $past(state_q) == ST_THETA)
		else $error("average update out of order");

endmodule

// ===== rtl/core/tae_cordic_lane.sv =====
module tae_cordic_lane (
	input  logic                    clk,
	input  tae_pkg::lane_ctl_t      ctl,
	input  logic signed [16:0]      y_in,
	input  logic signed [16:0]      x_in,
	output tae_pkg::theta_t         theta
);
	import tae_pkg::*;

	logic signed [XY_W-1:0] x_q, y_q, xe, ye, dx, dy;
	logic signed [Z_W-1:0]  z_q, tab;
	logic                   zero_q;
	logic signed [Z_W:0]    zr, zs;

	assign xe  = XY_W'(x_in);
	assign ye  = XY_W'(y_in);
	assign dx  = y_q >>> ctl.idx;
	assign dy  = x_q >>> ctl.idx;
	assign tab = $signed(Z_W'(atan_entry(ctl.idx)));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			zero_q <= (x_in == 17'sd0) && (y_in == 17'sd0);
			if (x_in < 0) begin
				x_q <= -xe;
				y_q <= -ye;
				z_q <= (y_in >= 0) ? $signed(ANGLE_PI) : -$signed(ANGLE_PI);
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (ctl.step) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - tab;
			end
		end
	end

	// Round to Q2.18 and saturate.
	assign zr = (Z_W+1)'(z_q) + (Z_W+1)'(8);
	assign zs = zr >>> 4;

	always_comb begin
		if (zero_q)
			theta = '0;
		else if (zs > (Z_W+1)'(THETA_MAX))
			theta = THETA_MAX;
		else if (zs < (Z_W+1)'(THETA_MIN))
			theta = THETA_MIN;
		else
			theta = zs[THETA_W-1:0];
	end

endmodule

// ===== rtl/core/tae_smooth.sv =====
module tae_smooth (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          capture,
	input  logic                          update,
	input  logic [tae_pkg::SHIFT_W-1:0]   shift,
	input  tae_pkg::theta_t               theta [tae_pkg::NUM_LANES],
	output tae_pkg::angle_t               angle [tae_pkg::NUM_LANES]
);
	import tae_pkg::*;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_avg
		theta_t                  theta_s1;
		theta_t                  avg_q;
		logic signed [THETA_W:0] diff, stp, nxt, rnd, sh;

		assign diff = (THETA_W+1)'(theta_s1) - (THETA_W+1)'(avg_q);
		assign stp  = diff >>> shift;
		assign nxt  = (THETA_W+1)'(avg_q) + stp;

		always_ff @(posedge clk) begin
			if (capture)
				theta_s1 <= theta[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				avg_q <= '0;
			end else if (update) begin
				avg_q <= nxt[THETA_W-1:0];
			end
		end

		assign rnd = (THETA_W+1)'(avg_q) + (THETA_W+1)'(8);
		assign sh  = rnd >>> 4;

		always_comb begin
			if (sh > (THETA_W+1)'(32767))
				angle[i] = 16'sh7FFF;
			else if (sh < -(THETA_W+1)'(32768))
				angle[i] = -16'sh8000;
			else
				angle[i] = sh[ANGLE_W-1:0];
		end
	end

endmodule

// ===== rtl/core/tae_rate.sv =====
module tae_rate (
	input  logic               clk,
	input  logic               load,
	input  logic signed [15:0] raw,
	output logic signed [15:0] rate
);
	import tae_pkg::*;

	logic [25:0] m_s1, m_s2, r;
	logic        neg_s1, neg_s2, neg_s3;
	logic [15:0] mag, q0_s2, q, q_s3;
	logic [46:0] prod;

	assign mag  = raw[15] ? 16'(-raw) : raw;
	assign prod = 47'(m_s1) * 47'(RATE_RECIP);
	assign r    = m_s2 - 26'(q0_s2) * 26'(RATE_DIV);
	assign q    = (r >= 26'(RATE_DIV)) ? q0_s2 + 16'd1 : q0_s2;

	always_ff @(posedge clk) begin
		if (load) begin
			m_s1   <= {mag[15:0], 10'd0} + 26'(RATE_BIAS);
			neg_s1 <= raw[15];
		end
		m_s2   <= m_s1;
		neg_s2 <= neg_s1;
		q0_s2  <= prod[46:31];
		neg_s3 <= neg_s2;
		q_s3   <= q;
	end

	assign rate = neg_s3 ? -$signed(q_s3) : $signed(q_s3);

endmodule

// ===== bench/tae_tb_pkg.sv =====
package tae_tb_pkg;

	timeunit 1ns;
	timeprecision 1ps;

	import tae_pkg::*;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic signed [15:0] roll_rate;
		logic signed [15:0] pitch_rate;
		logic signed [15:0] yaw_rate;
	} tilt_result_t;

	// Predicts tilt results and holds the ones still owed by the block.
	class tilt_scoreboard;
		int unsigned  errors;
		logic [2:0]   shift;
		int           avg_roll, avg_pitch, avg_yaw;
		tilt_result_t owed[$];

		function void clear();
			errors = 0;
			shift = SHIFT_RESET;
			avg_roll = 0;
			avg_pitch = 0;
			avg_yaw = 0;
			owed.delete();
		endfunction

		function int floor_shr(int v, int s);
			return v >>> s;
		endfunction

		function int sat(int v, int lo, int hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function int sensor_value(logic [15:0] w);
			logic [15:0] u;
			u = w[10] ? (w | 16'hF800) : w;
			return int'($signed(u));
		endfunction

		// Vectoring CORDIC atan2, result Q2.18 in units of pi/2.
		function int cordic_angle(int y, int x);
			int acc, ddx, ddy, n;
			int arctan[24];
			arctan = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
				20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
				5, 3, 1, 1, 0};
			acc = 0;
			if (x == 0 && y == 0)
				return 0;
			if (x < 0) begin
				acc = (y >= 0) ? 8388608 : -8388608;
				x = -x;
				y = -y;
			end
			n = CORDIC_STEPS_DEF > 24 ? 24 : CORDIC_STEPS_DEF;
			for (int i = 0; i < n; i++) begin
				ddx = floor_shr(y, i);
				ddy = floor_shr(x, i);
				if (y >= 0) begin
					x += ddx;
					y -= ddy;
					acc += arctan[i];
				end else begin
					x -= ddx;
					y += ddy;
					acc -= arctan[i];
				end
			end
			return sat(floor_shr(acc + 8, 4), -524288, 524287);
		endfunction

		function logic signed [15:0] angle_code(int avg);
			return 16'(sat(floor_shr(avg + 8, 4), -32768, 32767));
		endfunction

		function logic signed [15:0] rate_code(logic signed [15:0] g);
			int m, q;
			m = g < 0 ? -int'(g) : int'(g);
			q = (m * 4096 + 3000) / 6000;
			return 16'(g < 0 ? -q : q);
		endfunction

		function void note_sample(logic [15:0] ax_w, logic [15:0] ay_w,
				logic [15:0] az_w, logic signed [15:0] gx,
				logic signed [15:0] gy, logic signed [15:0] gz);
			int ax, ay, az;
			tilt_result_t r;
			ax = sensor_value(ax_w);
			ay = sensor_value(ay_w);
			az = sensor_value(az_w);
			avg_roll += floor_shr(cordic_angle(ax, az) - avg_roll, shift);
			avg_pitch += floor_shr(cordic_angle(-ay, az) - avg_pitch, shift);
			avg_yaw += floor_shr(cordic_angle(ay, ax) - avg_yaw, shift);
			r.roll_angle = angle_code(avg_roll);
			r.pitch_angle = angle_code(avg_pitch);
			r.yaw_angle = angle_code(avg_yaw);
			r.roll_rate = rate_code(gx);
			r.pitch_rate = rate_code(gy);
			r.yaw_rate = rate_code(gz);
			owed.push_back(r);
		endfunction

		function void compare(string name, int e, int a);
			if (e != a) begin
				$error("%s: expected %0d, actual %0d", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(tilt_result_t got);
			tilt_result_t e;
			if (owed.size() == 0) begin
				$error("result item with none expected");
				errors++;
				return;
			end
			e = owed.pop_front();
			compare("roll_angle", e.roll_angle, got.roll_angle);
			compare("pitch_angle", e.pitch_angle, got.pitch_angle);
			compare("yaw_angle", e.yaw_angle, got.yaw_angle);
			compare("roll_rate", e.roll_rate, got.roll_rate);
			compare("pitch_rate", e.pitch_rate, got.pitch_rate);
			compare("yaw_rate", e.yaw_rate, got.yaw_rate);
		endfunction
	endclass

endpackage

// ===== bench/tb_tilt_angle_estimator_unit.sv =====
// Testbench for the tilt angle estimator. Sample items go in on one channel,
// and each is predicted by the scoreboard, which keeps its own copy of the
// three smoothed averages and the smoothing shift. Every result item is
// compared field by field with the oldest prediction.
module tb_tilt_angle_estimator_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import tae_pkg::*;
	import tae_tb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	// Wait a comfortable margin beyond the latency of an item.
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [SHIFT_W-1:0] cfg_wdata = '0;

	// Idle chances in percent for sender and receiver.
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	int unsigned cycles = 0;

	tilt_scoreboard board;

	tae_in_if sample ();
	tae_out_if result ();

	tilt_angle_estimator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample.sink),
		.result   (result.source),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		sample.valid = 1'b0;
		sample.accel_x_word = '0;
		sample.accel_y_word = '0;
		sample.accel_z_word = '0;
		sample.gyro_x_raw = '0;
		sample.gyro_y_raw = '0;
		sample.gyro_z_raw = '0;
		result.ready = 1'b0;
	end

	// The receiver stalls at random; a result item is checked at the edge
	// where valid and ready are both high.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready)
				board.check_result({result.roll_angle, result.pitch_angle,
					result.yaw_angle, result.roll_rate, result.pitch_rate,
					result.yaw_rate});
			result.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// The watchdog ends a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Drives one sample item and holds it until accepted. Idle gaps come
	// before valid rises, so they land on every phase of the block's work.
	// Valid is dropped after the accept, while the block is busy.
	task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
			logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
		while ($urandom_range(99) < send_idle)
			@(posedge clk);
		sample.valid <= 1'b1;
		sample.accel_x_word <= ax;
		sample.accel_y_word <= ay;
		sample.accel_z_word <= az;
		sample.gyro_x_raw <= gx;
		sample.gyro_y_raw <= gy;
		sample.gyro_z_raw <= gz;
		do
			@(posedge clk);
		while (!sample.ready);
		board.note_sample(ax, ay, az, gx, gy, gz);
		sample.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every expected result item has come back.
	task automatic wait_drained();
		while (board.owed.size() != 0)
			@(posedge clk);
	endtask

	// Writes the smoothing shift; called only while the block is idle.
	task automatic write_shift(logic [SHIFT_W-1:0] value);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		board.shift = value;
	endtask

	// Random accelerometer word: mostly tilts from an 11-bit value with bits 15:11
	// set or clear at random, sometimes small values, sometimes any 16-bit pattern.
	function automatic logic [15:0] accel_word();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 6)
			return 16'($urandom_range(2047)) | ($urandom_range(1) ? 16'h0 : 16'hF800);
		if (pick < 8)
			return 16'($signed($urandom_range(8)) - 4);
		return 16'($urandom);
	endfunction

	task automatic random_samples(int count);
		repeat (count)
			send_sample(accel_word(), accel_word(), accel_word(),
				16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset shift: both operands zero, negative x with
		// zero y (plus pi, which saturates), axis directions, field extremes,
		// a word with bit 10 clear but upper bits set, and gyro extremes.
		send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'hFC00, 16'h7FFF, 16'h8000, 16'hFFFF);
		send_sample(16'h0000, 16'h0000, 16'h03FF, 16'h0001, 16'h8001, 16'h0BB8);
		send_sample(16'h03FF, 16'h0000, 16'h0000, 16'hF448, 16'h0177, 16'hFE89);
		send_sample(16'hFC00, 16'h03FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'hFC00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h7800, 16'h8000, 16'h7BFF, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0000);
		send_sample(16'h0200, 16'h0200, 16'hFE00, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'hFE00, 16'hFE00, 16'hFE00, 16'h0000, 16'h0000, 16'h0000);

		// A zero shift makes the averages jump to each new angle.
		write_shift(3'd0);
		send_sample(16'h0000, 16'h0000, 16'hFC00, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'hFC00, 16'hFC00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0001, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		write_shift(3'd7);
		send_sample(16'h03FF, 16'h03FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h03FF, 16'h03FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

		// Random part: shifts change between phases, idling patterns rotate.
		send_idle = 29;
		recv_idle = 57;
		write_shift(3'd1);
		random_samples(90);
		write_shift(3'($urandom_range(7)));
		random_samples(90);
		// Hold off the sender until the block has returned everything.
		wait_drained();
		send_idle = 57;
		recv_idle = 29;
		write_shift(3'd7);
		random_samples(90);
		write_shift(3'd0);
		random_samples(90);
		send_idle = 0;
		recv_idle = 0;
		write_shift(3'd3);
		random_samples(90);
		write_shift(3'($urandom_range(7)));
		random_samples(84);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.owed.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/tae_pkg.sv
rtl/core/tae_if.sv
rtl/core/tae_cordic_lane.sv
rtl/core/tae_smooth.sv
rtl/core/tae_rate.sv
rtl/core/tilt_angle_estimator_unit.sv
bench/tae_tb_pkg.sv
bench/tb_tilt_angle_estimator_unit.sv
